>>> rtl/u16to8_pkg.sv
// Shared widths and byte-pattern constants for the UTF-16 to UTF-8 encoder.
// No dependencies; used by the core and by its port checker.
`timescale 1ns / 1ps

package u16to8_pkg;

    localparam int CU_W      = 16;  // width of one UTF-16 code unit
    localparam int BYTE_W    = 8;   // width of one UTF-8 byte
    localparam int MAX_BYTES = 4;   // longest encoding of one code point
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int OFS_W     = 10;  // payload bits of one surrogate
    localparam int CP_W      = 21;  // width of a Unicode code point

    // Top six bits of a code unit that mark a surrogate.
    localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;

    // Start of the supplementary planes.
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // Lead and continuation byte markers.
    localparam logic [BYTE_W-1:0] LEAD2 = 8'b1100_0000;
    localparam logic [BYTE_W-1:0] LEAD3 = 8'b1110_0000;
    localparam logic [BYTE_W-1:0] LEAD4 = 8'b1111_0000;
    localparam logic [BYTE_W-1:0] CONT  = 8'b1000_0000;

    localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

>>> rtl/utf16_to_utf8_encoder_core.sv
// Streaming UTF-16 to UTF-8 encoder core: one code unit in, up to four bytes out.
// Depends on u16to8_pkg for widths and byte constants.
`timescale 1ns / 1ps
// Flow: an accepted unit waits in the input register until the byte buffer is
// free, is then decoded into the buffer, and its first byte is on the port
// from buffer byte 0. An empty input register takes the next unit while the buffer still sends bytes.
// Output rate: one byte per cycle while i_m_axis_tready is high, from the byte
// buffer shifting down on each accepted word. A BMP unit gives 1 to 3 bytes,
// a surrogate pair 4 in total, and a held high surrogate or a dropped unit none.
// Reset (i_rst_n low, synchronous) empties both stages and drops any held
// high surrogate.

module utf16_to_utf8_encoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream of code units.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [u16to8_pkg::CU_W-1:0]    i_s_axis_tdata,  // [15:0] code_unit
    input  logic                           i_s_axis_tlast,  // last_unit
    // Output stream of UTF-8 bytes.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [u16to8_pkg::BYTE_W-1:0]  o_m_axis_tdata,  // [7:0] utf8_byte
    output logic                           o_m_axis_tlast   // last_byte
);

    localparam int BW = u16to8_pkg::BYTE_W;
    localparam int NB = u16to8_pkg::MAX_BYTES;
    localparam int CW = u16to8_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Input register. It is free when empty, or when its word moves into
    // the byte buffer in this cycle.
    // ------------------------------------------------------------------
    logic                        r_in_valid;
    logic [u16to8_pkg::CU_W-1:0] r_cu;
    logic                        r_last;

    // Held high surrogate.
    logic                          r_pend_valid;
    logic [u16to8_pkg::OFS_W-1:0]  r_pend_high;
    logic                          n_pend_valid;
    logic [u16to8_pkg::OFS_W-1:0]  n_pend_high;

    // Byte buffer: byte 0 is the one on the output port; it shifts down
    // by one on each accepted output word that does not coincide with a load.
    logic [BW-1:0] r_buf [NB];
    logic [CW-1:0] r_left;

    logic out_fire;
    logic buf_free;
    logic in_fire;
    logic load;

    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    // The buffer is free when empty or when its final byte leaves now.
    assign buf_free = (r_left == '0) || (out_fire && (r_left == CW'(1)));
    assign load     = r_in_valid && buf_free;

    assign o_s_axis_tready = !r_in_valid || buf_free;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = (r_left != '0);
    assign o_m_axis_tdata  = r_buf[0];
    assign o_m_axis_tlast  = (r_left == CW'(1));

    // ------------------------------------------------------------------
    // Decode of the registered unit into its bytes.
    // ------------------------------------------------------------------
    logic                         is_high;
    logic                         is_low;
    logic [u16to8_pkg::CP_W-1:0]  cp;
    logic [BW-1:0]                dec_byte [NB];
    logic [CW-1:0]                dec_cnt;

    assign is_high = (r_cu[15:10] == u16to8_pkg::HIGH_SUR_TAG);
    assign is_low  = (r_cu[15:10] == u16to8_pkg::LOW_SUR_TAG);
    // Surrogate offsets are combined and rebased onto the supplementary planes.
    assign cp = {1'b0, r_pend_high, r_cu[9:0]} + u16to8_pkg::SUPP_BASE;

    always_comb begin
        dec_cnt      = '0;
        n_pend_valid = r_pend_valid;
        n_pend_high  = r_pend_high;
        for (int k = 0; k < NB; k++) begin
            dec_byte[k] = '0;
        end
        if (r_pend_valid) begin
            // A held high surrogate is always consumed by the next unit; only
            // a low surrogate completes it, anything else drops both.
            n_pend_valid = 1'b0;
            n_pend_high  = '0;
            if (is_low) begin
                dec_cnt     = CW'(4);
                dec_byte[0] = u16to8_pkg::LEAD4 | BW'(cp[20:18]);
                dec_byte[1] = u16to8_pkg::CONT | BW'(cp[17:12]);
                dec_byte[2] = u16to8_pkg::CONT | BW'(cp[11:6]);
                dec_byte[3] = u16to8_pkg::CONT | BW'(cp[5:0]);
            end
        end else if (is_high) begin
            // Held for the next unit unless the string ends here.
            n_pend_valid = !r_last;
            n_pend_high  = r_last ? '0 : r_cu[9:0];
        end else if (is_low) begin
            // A lone low surrogate is dropped.
            dec_cnt = '0;
        end else if (r_cu[15:7] == '0) begin
            dec_cnt     = CW'(1);
            dec_byte[0] = r_cu[7:0];
        end else if (r_cu[15:11] == '0) begin
            dec_cnt     = CW'(2);
            dec_byte[0] = u16to8_pkg::LEAD2 | BW'(r_cu[10:6]);
            dec_byte[1] = u16to8_pkg::CONT | BW'(r_cu[5:0]);
        end else begin
            dec_cnt     = CW'(3);
            dec_byte[0] = u16to8_pkg::LEAD3 | BW'(r_cu[15:12]);
            dec_byte[1] = u16to8_pkg::CONT | BW'(r_cu[11:6]);
            dec_byte[2] = u16to8_pkg::CONT | BW'(r_cu[5:0]);
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_high  <= '0;
            r_left       <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_pend_valid <= n_pend_valid;
                r_pend_high  <= n_pend_high;
                r_left       <= dec_cnt;
            end else if (out_fire) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cu   <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
        if (load) begin
            for (int k = 0; k < NB; k++) begin
                r_buf[k] <= dec_byte[k];
            end
        end else if (out_fire) begin
            for (int k = 0; k < NB - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
            r_buf[NB-1] <= '0;
        end
    end

endmodule

>>> rtl/u16to8_checker.sv
// Port-level checker for the UTF-16 to UTF-8 encoder core, bound to the core.
// Depends on u16to8_pkg for port widths.
`timescale 1ns / 1ps

module u16to8_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [u16to8_pkg::CU_W-1:0]    i_s_axis_tdata,  // [15:0] code_unit
    input logic                           i_s_axis_tlast,  // last_unit
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [u16to8_pkg::BYTE_W-1:0]  o_m_axis_tdata,  // [7:0] utf8_byte
    input logic                           o_m_axis_tlast   // last_byte
);

    // A stalled output word holds its byte and marker.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    // After a byte that is not the last of its character, a continuation
    // byte follows at once.
    a_cont_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && (o_m_axis_tdata[7:6] == u16to8_pkg::CONT_TAG))
        else $error("missing continuation byte");

    // A single-byte character is plain ASCII.
    a_single_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast &&
            (o_m_axis_tdata[7:6] != u16to8_pkg::CONT_TAG) |-> !o_m_axis_tdata[7])
        else $error("lone lead byte is not ASCII");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind utf16_to_utf8_encoder_core u16to8_checker u_u16to8_checker (.*);
